### hdl/cum_pkg.sv
// Shared types and constants of the cherish/urgency multiplexer.
package cum_pkg;

    localparam int ID_W    = 8;
    localparam int LVL_W   = 4;
    localparam int THR_W   = 7;
    localparam int TOT_W   = 7;
    localparam int NUM_THR = 4;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried in func
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_C0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_C1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_C2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_C3 = 2'd3;

    // Threshold reset values
    localparam logic [THR_W-1:0] THR_C0_RST = 7'd40;
    localparam logic [THR_W-1:0] THR_C1_RST = 7'd30;
    localparam logic [THR_W-1:0] THR_C2_RST = 7'd20;
    localparam logic [THR_W-1:0] THR_C3_RST = 7'd10;

    // Highest cherish level with a threshold register of its own
    localparam logic [LVL_W-1:0] THR_TOP = 4'(NUM_THR - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic exec;      // decide and update queue state
        logic load_rd;   // build the dequeue result from the store read data
    } cum_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic res_free;     // result register empty or being emptied
        logic deq_pending;  // latched item is a dequeue that finds an entry
    } cum_stat_t;

endpackage

### hdl/cum_if.sv
// Item and result channel interfaces.
interface cum_item_if
    import cum_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             func;
    logic [ID_W-1:0]  item_id;
    logic [LVL_W-1:0] urgency;
    logic [LVL_W-1:0] cherish;
    logic             output_ready;

    modport source (output valid, func, item_id, urgency, cherish, output_ready,
                    input ready);
    modport sink   (input valid, func, item_id, urgency, cherish, output_ready,
                    output ready);
endinterface

interface cum_result_if
    import cum_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             admitted;
    logic             dropped;
    logic             wake_output;
    logic             served_valid;
    logic [ID_W-1:0]  served_id;
    logic [TOT_W-1:0] total_held;

    modport source (output valid, admitted, dropped, wake_output, served_valid,
                    served_id, total_held, input ready);
    modport sink   (input valid, admitted, dropped, wake_output, served_valid,
                    served_id, total_held, output ready);
endinterface

### hdl/cum_datapath.sv
// Datapath: thresholds, per-level queue pointers, item store and result register.
module cum_datapath
    import cum_pkg::*;
#(
    parameter int NUM_URGENCY = 4,
    parameter int NUM_CHERISH = 4,
    parameter int FIFO_DEPTH  = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    input  logic                 in_func,
    input  logic [ID_W-1:0]      in_item_id,
    input  logic [LVL_W-1:0]     in_urgency,
    input  logic [LVL_W-1:0]     in_cherish,
    input  logic                 in_output_ready,
    input  logic                 out_ready,
    input  cum_cmd_t             cmd,
    output cum_stat_t            stat,
    output logic                 out_valid,
    output logic                 out_admitted,
    output logic                 out_dropped,
    output logic                 out_wake_output,
    output logic                 out_served_valid,
    output logic [ID_W-1:0]      out_served_id,
    output logic [TOT_W-1:0]     out_total_held
);

    localparam int LW        = (NUM_URGENCY > 1) ? $clog2(NUM_URGENCY) : 1;
    localparam int PW        = $clog2(FIFO_DEPTH);
    localparam int CW        = $clog2(FIFO_DEPTH + 1);
    localparam int KW        = (CW > THR_W) ? CW : THR_W;
    localparam int MEM_DEPTH = NUM_URGENCY * FIFO_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [LVL_W-1:0] URG_TOP   = LVL_W'(NUM_URGENCY - 1);
    localparam logic [LVL_W-1:0] CHR_TOP   = LVL_W'(NUM_CHERISH - 1);
    localparam logic [PW-1:0]    PTR_LAST  = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0]    FILL_FULL = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0]    LVL_SPAN  = AW'(FIFO_DEPTH);

    // Latched item
    logic             func_reg;
    logic [ID_W-1:0]  id_reg;
    logic [LVL_W-1:0] urg_reg;
    logic [LVL_W-1:0] cher_reg;
    logic             ordy_reg;

    // Configuration and queue state
    logic [THR_W-1:0] thr_reg  [NUM_THR];
    logic [PW-1:0]    head_reg [NUM_URGENCY];
    logic [PW-1:0]    tail_reg [NUM_URGENCY];
    logic [CW-1:0]    fill_reg [NUM_URGENCY];
    logic [CW-1:0]    count_reg;

    // Item store
    logic [ID_W-1:0]  mem [MEM_DEPTH];
    logic [ID_W-1:0]  rd_data_reg;

    // Result register
    logic             res_valid_reg;
    logic             res_admitted_reg;
    logic             res_dropped_reg;
    logic             res_wake_reg;
    logic             res_served_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic [TOT_W-1:0] res_total_reg;

    // Decision signals
    logic [LVL_W-1:0] urg_clamp;
    logic [LVL_W-1:0] cher_clamp;
    logic [1:0]       thr_idx;
    logic [THR_W-1:0] thr_sel;
    logic [LW-1:0]    enq_lvl;
    logic [LW-1:0]    deq_lvl;
    logic             deq_hit;
    logic             enq_ok;
    logic             is_deq;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             res_take;

    // Clamp levels and pick the threshold
    always_comb
    begin
        urg_clamp  = (urg_reg > URG_TOP) ? URG_TOP : urg_reg;
        cher_clamp = (cher_reg > CHR_TOP) ? CHR_TOP : cher_reg;
        thr_idx    = (cher_clamp > THR_TOP) ? THR_TOP[1:0] : cher_clamp[1:0];
        thr_sel    = thr_reg[thr_idx];
        enq_lvl    = LW'(urg_clamp);
    end

    // Admission test
    assign enq_ok = !(KW'(count_reg) > KW'(thr_sel)) &&
                    !(count_reg >= FILL_FULL) &&
                    !(fill_reg[enq_lvl] >= FILL_FULL);

    // Find the most urgent non-empty level
    always_comb
    begin
        deq_hit = 1'b0;
        deq_lvl = '0;
        for (int i = NUM_URGENCY - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                deq_hit = 1'b1;
                deq_lvl = LW'(i);
            end
        end
    end

    assign is_deq = (func_reg == FUNC_DEQ);

    // Count after this step
    always_comb
    begin
        count_next = count_reg;
        if (!is_deq)
        begin
            if (enq_ok)
                count_next = count_reg + CW'(1);
        end
        else if (deq_hit && count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign wr_addr = AW'(enq_lvl) * LVL_SPAN + AW'(tail_reg[enq_lvl]);
    assign rd_addr = AW'(deq_lvl) * LVL_SPAN + AW'(head_reg[deq_lvl]);

    assign res_take         = res_valid_reg && out_ready;
    assign stat.res_free    = !res_valid_reg || out_ready;
    assign stat.deq_pending = is_deq && deq_hit;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_func;
            id_reg   <= in_item_id;
            urg_reg  <= in_urgency;
            cher_reg <= in_cherish;
            ordy_reg <= in_output_ready;
        end
    end

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0] <= THR_C0_RST;
            thr_reg[1] <= THR_C1_RST;
            thr_reg[2] <= THR_C2_RST;
            thr_reg[3] <= THR_C3_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR_C0: thr_reg[0] <= cfg_data;
                CFG_THR_C1: thr_reg[1] <= cfg_data;
                CFG_THR_C2: thr_reg[2] <= cfg_data;
                CFG_THR_C3: thr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance pointers, fills and total count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_URGENCY; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
            if (!is_deq)
            begin
                if (enq_ok)
                begin
                    tail_reg[enq_lvl] <= (tail_reg[enq_lvl] == PTR_LAST) ? '0 :
                                         tail_reg[enq_lvl] + PW'(1);
                    fill_reg[enq_lvl] <= fill_reg[enq_lvl] + CW'(1);
                end
            end
            else if (deq_hit)
            begin
                head_reg[deq_lvl] <= (head_reg[deq_lvl] == PTR_LAST) ? '0 :
                                     head_reg[deq_lvl] + PW'(1);
                fill_reg[deq_lvl] <= fill_reg[deq_lvl] - CW'(1);
            end
        end
    end

    // Item store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !is_deq && enq_ok)
            mem[wr_addr] <= id_reg;
        if (cmd.exec && is_deq && deq_hit)
            rd_data_reg <= mem[rd_addr];
    end

    // Result register: load on a finished step, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.load_rd || (cmd.exec && !(is_deq && deq_hit)))
            res_valid_reg <= 1'b1;
        else if (res_take)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rd)
        begin
            res_admitted_reg <= 1'b0;
            res_dropped_reg  <= 1'b0;
            res_wake_reg     <= 1'b0;
            res_served_reg   <= 1'b1;
            res_id_reg       <= rd_data_reg;
            res_total_reg    <= TOT_W'(count_reg);
        end
        else if (cmd.exec && !(is_deq && deq_hit))
        begin
            res_admitted_reg <= !is_deq && enq_ok;
            res_dropped_reg  <= !is_deq && !enq_ok;
            res_wake_reg     <= !is_deq && enq_ok && ordy_reg &&
                                (count_next == CW'(1));
            res_served_reg   <= 1'b0;
            res_id_reg       <= '0;
            res_total_reg    <= TOT_W'(count_next);
        end
    end

    assign out_valid        = res_valid_reg;
    assign out_admitted     = res_admitted_reg;
    assign out_dropped      = res_dropped_reg;
    assign out_wake_output  = res_wake_reg;
    assign out_served_valid = res_served_reg;
    assign out_served_id    = res_id_reg;
    assign out_total_held   = res_total_reg;

endmodule

### hdl/cum_ctrl.sv
// Controller: sequences capture, execution and store read of one item.
module cum_ctrl
    import cum_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cum_stat_t stat,
    output cum_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.res_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.deq_pending ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.load_rd = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/cherish_urgency_mux_top.sv
// Top level of the cherish/urgency multiplexer.
// Each input item is an enqueue or a dequeue and yields exactly one result. An
// enqueue is admitted into the FIFO of its urgency level unless the total held
// exceeds the threshold of its cherish level, the total held reaches FIFO_DEPTH
// or the FIFO of its level is full; a dequeue serves the head of the most
// urgent non-empty level. Items are taken one at a time: an item is accepted,
// then its step executes once the output register is free and loads the result
// of an enqueue or an empty dequeue; a dequeue that finds an item loads its
// result in another state from the registered item store read. The next item
// is accepted once the step and any read are done, even while a result waits
// in the output register; execution holds only while that register is still
// full. Threshold writes take effect at once and are meant for idle periods.
module cherish_urgency_mux_top
    import cum_pkg::*;
#(
    parameter int NUM_URGENCY = 4,
    parameter int NUM_CHERISH = 4,
    parameter int FIFO_DEPTH  = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cum_item_if.sink             item_in,
    cum_result_if.source         result_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    cum_cmd_t  cmd;
    cum_stat_t stat;

    // Sequence each item
    cum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Queue state and result
    cum_datapath #(
        .NUM_URGENCY (NUM_URGENCY),
        .NUM_CHERISH (NUM_CHERISH),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_func          (item_in.func),
        .in_item_id       (item_in.item_id),
        .in_urgency       (item_in.urgency),
        .in_cherish       (item_in.cherish),
        .in_output_ready  (item_in.output_ready),
        .out_ready        (result_out.ready),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (result_out.valid),
        .out_admitted     (result_out.admitted),
        .out_dropped      (result_out.dropped),
        .out_wake_output  (result_out.wake_output),
        .out_served_valid (result_out.served_valid),
        .out_served_id    (result_out.served_id),
        .out_total_held   (result_out.total_held)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for the cherish/urgency multiplexer: admit, drop and serve checks.
module testbench;
    import cum_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_URG       = 4;
    localparam int NUM_CHER      = 4;
    localparam int DEPTH         = 64;
    localparam int SETTLE_CYCLES = 5;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  item_id;
        logic [LVL_W-1:0] urgency;
        logic [LVL_W-1:0] cherish;
        logic             output_ready;
    } mux_item_t;

    typedef struct packed {
        logic             admitted;
        logic             dropped;
        logic             wake_output;
        logic             served_valid;
        logic [ID_W-1:0]  served_id;
        logic [TOT_W-1:0] total_held;
    } mux_outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;

    cum_item_if   item_if ();
    cum_result_if res_if ();

    // Shadow of the queue state and the threshold registers
    logic [ID_W-1:0] shadow_store [NUM_URG][DEPTH];
    int              lvl_head [NUM_URG];
    int              lvl_tail [NUM_URG];
    int              lvl_fill [NUM_URG];
    int              held_total;
    int              thr_shadow [NUM_THR];

    mux_item_t       item_backlog [$];
    mux_outcome_t    outcome_q [$];
    mux_item_t       drv_item;
    int              results_due = 0;
    int              err_count = 0;
    int              src_gap = 0;
    int              snk_gap = 0;
    int              quiet_cycles;
    logic            idle_en = 1'b1;

    cherish_urgency_mux_top #(
        .NUM_URGENCY (NUM_URG),
        .NUM_CHERISH (NUM_CHER),
        .FIFO_DEPTH  (DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Admit, drop or serve one item against the shadow state
    function automatic mux_outcome_t next_outcome(input mux_item_t it);
        mux_outcome_t o;
        int           urg;
        int           cher;
        logic         found;
        o = '0;
        found = 1'b0;
        if (it.func == FUNC_ENQ)
        begin
            urg  = (int'(it.urgency) > NUM_URG - 1) ? NUM_URG - 1 : int'(it.urgency);
            cher = (int'(it.cherish) > NUM_CHER - 1) ? NUM_CHER - 1 : int'(it.cherish);
            if (cher > NUM_THR - 1)
                cher = NUM_THR - 1;
            if (held_total > thr_shadow[cher] || held_total >= DEPTH || lvl_fill[urg] >= DEPTH)
                o.dropped = 1'b1;
            else
            begin
                shadow_store[urg][lvl_tail[urg]] = it.item_id;
                lvl_tail[urg] = (lvl_tail[urg] + 1) % DEPTH;
                lvl_fill[urg]++;
                held_total++;
                o.admitted = 1'b1;
                o.wake_output = (held_total == 1) && it.output_ready;
            end
        end
        else
        begin
            // Serve the most urgent non-empty level
            for (int i = 0; i < NUM_URG; i++)
            begin
                if (!found && lvl_fill[i] != 0)
                begin
                    found = 1'b1;
                    o.served_valid = 1'b1;
                    o.served_id = shadow_store[i][lvl_head[i]];
                    lvl_head[i] = (lvl_head[i] + 1) % DEPTH;
                    lvl_fill[i]--;
                    held_total--;
                end
            end
        end
        o.total_held = TOT_W'(held_total);
        return o;
    endfunction

    task automatic check_outcome(input mux_outcome_t got);
        mux_outcome_t want;
        if (outcome_q.size() == 0)
        begin
            report_mismatch("result with nothing pending, total_held", got.total_held, 0);
            return;
        end
        want = outcome_q.pop_front();
        if (got.admitted !== want.admitted)
            report_mismatch("admitted", got.admitted, want.admitted);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (got.wake_output !== want.wake_output)
            report_mismatch("wake_output", got.wake_output, want.wake_output);
        if (got.served_valid !== want.served_valid)
            report_mismatch("served_valid", got.served_valid, want.served_valid);
        if (got.served_id !== want.served_id)
            report_mismatch("served_id", got.served_id, want.served_id);
        if (got.total_held !== want.total_held)
            report_mismatch("total_held", got.total_held, want.total_held);
    endtask

    // Present items from the backlog, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
                outcome_q = {outcome_q, next_outcome(drv_item)};
            if (!item_if.valid || item_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_if.valid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    drv_item = item_backlog.pop_front();
                    results_due++;
                    item_if.valid        <= 1'b1;
                    item_if.func         <= drv_item.func;
                    item_if.item_id      <= drv_item.item_id;
                    item_if.urgency      <= drv_item.urgency;
                    item_if.cherish      <= drv_item.cherish;
                    item_if.output_ready <= drv_item.output_ready;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 3);
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Take results with random stalls and check each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                check_outcome({res_if.admitted, res_if.dropped, res_if.wake_output,
                               res_if.served_valid, res_if.served_id, res_if.total_held});
                results_due--;
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 4) == 0)
                    snk_gap = $urandom_range(1, 3);
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic add_item(input logic func, input int id, input int urg, input int cher,
                            input logic rdy);
        mux_item_t it;
        it.func         = func;
        it.item_id      = ID_W'(id);
        it.urgency      = LVL_W'(urg);
        it.cherish      = LVL_W'(cher);
        it.output_ready = rdy;
        item_backlog = {item_backlog, it};
    endtask

    // Queue random items, mostly in-range levels with some above the top level
    task automatic add_random(input int count, input int enq_pct);
        mux_item_t it;
        repeat (count)
        begin
            it.func    = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            it.item_id = ID_W'($urandom_range(0, 255));
            it.urgency = ($urandom_range(0, 4) == 0) ? LVL_W'($urandom_range(0, 15))
                                                      : LVL_W'($urandom_range(0, NUM_URG - 1));
            it.cherish = ($urandom_range(0, 4) == 0) ? LVL_W'($urandom_range(0, 15))
                                                      : LVL_W'($urandom_range(0, NUM_CHER - 1));
            it.output_ready = 1'($urandom_range(0, 1));
            item_backlog = {item_backlog, it};
        end
    endtask

    // Hold until every queued item has its result, then let the block settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= THR_W'(value);
        thr_shadow[idx] = value;
    endtask

    task automatic set_thresholds(input int t0, input int t1, input int t2, input int t3);
        write_threshold(CFG_THR_C0, t0);
        write_threshold(CFG_THR_C1, t1);
        write_threshold(CFG_THR_C2, t2);
        write_threshold(CFG_THR_C3, t3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cfg_we               = 1'b0;
        cfg_index            = CFG_THR_C0;
        cfg_data             = '0;
        item_if.valid        = 1'b0;
        item_if.func         = FUNC_ENQ;
        item_if.item_id      = '0;
        item_if.urgency      = '0;
        item_if.cherish      = '0;
        item_if.output_ready = 1'b0;
        res_if.ready         = 1'b0;
        held_total           = 0;
        for (int i = 0; i < NUM_URG; i++)
        begin
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
            lvl_fill[i] = 0;
        end
        thr_shadow[CFG_THR_C0] = THR_C0_RST;
        thr_shadow[CFG_THR_C1] = THR_C1_RST;
        thr_shadow[CFG_THR_C2] = THR_C2_RST;
        thr_shadow[CFG_THR_C3] = THR_C3_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds: empty dequeue, clamps, wake, priority order, FIFO order
        add_item(FUNC_DEQ, 8'hFF, 15, 15, 1'b1);
        add_item(FUNC_ENQ, 8'hFF, 15, 15, 1'b1);
        add_item(FUNC_ENQ, 8'h00, 0, 0, 1'b1);
        add_item(FUNC_ENQ, 8'hA5, 2, 7, 1'b0);
        add_item(FUNC_ENQ, 8'h5A, 1, 1, 1'b1);
        add_item(FUNC_ENQ, 8'h3C, 3, 2, 1'b0);
        repeat (6) add_item(FUNC_DEQ, 8'h00, 0, 0, 1'b0);
        add_item(FUNC_ENQ, 8'h81, 8, 3, 1'b0);
        add_item(FUNC_DEQ, 8'h7E, 12, 9, 1'b1);
        add_random(300, 55);
        wait_idle();

        // All thresholds at zero: admit only into an empty store
        set_thresholds(0, 0, 0, 0);
        add_item(FUNC_DEQ, 8'h11, 0, 0, 1'b0);
        add_item(FUNC_DEQ, 8'h11, 0, 0, 1'b0);
        add_item(FUNC_ENQ, 8'h42, 0, 3, 1'b1);
        add_item(FUNC_ENQ, 8'h24, 1, 0, 1'b1);
        add_item(FUNC_DEQ, 8'h00, 0, 0, 1'b0);
        add_random(200, 50);
        wait_idle();

        // All thresholds at 64: fill the store until it is full, then drain
        set_thresholds(64, 64, 64, 64);
        add_random(220, 90);
        add_random(220, 25);
        wait_idle();

        // Random thresholds
        set_thresholds($urandom_range(0, 64), $urandom_range(0, 64),
                       $urandom_range(0, 64), $urandom_range(0, 64));
        add_random(300, 60);
        wait_idle();

        set_thresholds(64, 0, 33, 1);
        add_random(250, 65);
        wait_idle();

        // Reset values again, no idling on either side
        idle_en = 1'b0;
        set_thresholds(THR_C0_RST, THR_C1_RST, THR_C2_RST, THR_C3_RST);
        add_random(300, 55);
        wait_idle();
        repeat (10) @(posedge clk);

        if (outcome_q.size() != 0)
            report_mismatch("results never delivered", 0, outcome_q.size());
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### cherish_urgency_mux_top.f
hdl/cum_pkg.sv
hdl/cum_if.sv
hdl/cum_datapath.sv
hdl/cum_ctrl.sv
hdl/cherish_urgency_mux_top.sv
tb/testbench.sv
